// ===== hw/rtl/aes128_pkg.sv =====
`default_nettype none
package aes128_pkg;

    localparam int NumRounds = 10;

    localparam logic [0:0] OpEncrypt = 1'b0;
    localparam logic [0:0] OpDecrypt = 1'b1;

    localparam logic [0:0] CfgKeyUpper = 1'b0;
    localparam logic [0:0] CfgKeyLower = 1'b1;

    typedef logic [127:0] t_block;
    typedef logic [7:0]   t_byte;

    localparam logic [7:0] FwdSub [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam logic [7:0] InvSub [256] = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
    };

    // byte i of a block sits at bits 127-8i downto 120-8i
    function automatic logic [7:0] get_byte(input logic [127:0] b, input int i);
        return b[127 - 8 * i -: 8];
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] b);
        return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [127:0] sub_bytes(input logic [127:0] s, input logic inv);
        logic [127:0] r;
        r = '0;
        for (int i = 0; i < 16; i++) begin
            r[127 - 8 * i -: 8] = inv ? InvSub[get_byte(s, i)] : FwdSub[get_byte(s, i)];
        end
        return r;
    endfunction

    function automatic logic [127:0] shift_rows(input logic [127:0] s, input logic inv);
        logic [127:0] r;
        r = '0;
        for (int row = 0; row < 4; row++) begin
            for (int c = 0; c < 4; c++) begin
                if (inv) begin
                    r[127 - 8 * (row + 4 * ((c + row) % 4)) -: 8] = get_byte(s, row + 4 * c);
                end else begin
                    r[127 - 8 * (row + 4 * c) -: 8] = get_byte(s, row + 4 * ((c + row) % 4));
                end
            end
        end
        return r;
    endfunction

    function automatic logic [127:0] mix_columns(input logic [127:0] s, input logic inv);
        logic [127:0] r;
        logic [7:0]   a [4];
        logic [7:0]   a2 [4];
        logic [7:0]   a4 [4];
        logic [7:0]   a8 [4];
        logic [7:0]   m [4];
        r = '0;
        for (int c = 0; c < 4; c++) begin
            for (int k = 0; k < 4; k++) begin
                a[k]  = get_byte(s, 4 * c + k);
                a2[k] = xtime(a[k]);
                a4[k] = xtime(a2[k]);
                a8[k] = xtime(a4[k]);
            end
            for (int row = 0; row < 4; row++) begin
                r[127 - 8 * (4 * c + row) -: 8] = 8'h00;
                for (int k = 0; k < 4; k++) begin
                    // coefficient for column entry k of output row
                    case ((k - row + 4) % 4)
                        0: m[k] = inv ? (a8[k] ^ a4[k] ^ a2[k]) : a2[k];
                        1: m[k] = inv ? (a8[k] ^ a2[k] ^ a[k]) : (a2[k] ^ a[k]);
                        2: m[k] = inv ? (a8[k] ^ a4[k] ^ a[k]) : a[k];
                        default: m[k] = inv ? (a8[k] ^ a[k]) : a[k];
                    endcase
                    r[127 - 8 * (4 * c + row) -: 8] = r[127 - 8 * (4 * c + row) -: 8] ^ m[k];
                end
            end
        end
        return r;
    endfunction

    // one key schedule step: round key n from round key n-1
    function automatic logic [127:0] next_key(input logic [127:0] k, input logic [7:0] rc);
        logic [31:0]  t;
        logic [127:0] r;
        t = {FwdSub[k[23:16]] ^ rc, FwdSub[k[15:8]], FwdSub[k[7:0]], FwdSub[k[31:24]]};
        r[127:96] = k[127:96] ^ t;
        r[95:64]  = k[95:64] ^ r[127:96];
        r[63:32]  = k[63:32] ^ r[95:64];
        r[31:0]   = k[31:0] ^ r[63:32];
        return r;
    endfunction

    localparam logic [7:0] Rcon [10] = '{
        8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
    };

endpackage
`default_nettype wire

// ===== hw/rtl/aes128_block_cipher.sv =====
`default_nettype none
// AES-128 encrypt/decrypt engine, fully unrolled: a first stage does the initial
// key xor, then one register stage per round (ten), and the result of an item is
// offered from the last round stage. A new item may enter every cycle while the output
// is not stalled and the key table is full. Round keys are expanded from the key registers
// into a key table, one round key per cycle; input ready stays low after reset and after
// each key write while the table refills. The block expects config only while idle.
// Output is held in the last stage; a stall backs up only through full stages.
module aes128_block_cipher (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic        i_operation,
    input  wire logic [63:0] i_block_upper,
    input  wire logic [63:0] i_block_lower,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [63:0]      o_out_upper,
    output logic [63:0]      o_out_lower,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [63:0] i_cfg_index,
    input  wire logic [63:0] i_cfg_data
);

    localparam int NStage = aes128_pkg::NumRounds + 1;

    logic [63:0]  r_key_upper;
    logic [63:0]  r_key_lower;
    logic [127:0] r_rk [NStage];
    logic [3:0]   r_kx_cnt;

    logic [127:0] r_st   [NStage];
    logic         r_op   [NStage];
    logic         r_vld  [NStage];
    logic         w_adv  [NStage];

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_upper <= '0;
            r_key_lower <= '0;
            r_kx_cnt    <= 4'd0;
        end else begin
            if (i_cfg_valid && i_cfg_index == {63'd0, aes128_pkg::CfgKeyUpper}) begin
                r_key_upper <= i_cfg_data;
                r_kx_cnt    <= 4'd0;
            end else if (i_cfg_valid && i_cfg_index == {63'd0, aes128_pkg::CfgKeyLower}) begin
                r_key_lower <= i_cfg_data;
                r_kx_cnt    <= 4'd0;
            end else if (r_kx_cnt != 4'(NStage)) begin
                r_kx_cnt <= r_kx_cnt + 4'd1;
            end
        end
    end

    // key expansion: one round key per cycle, restarted on each key write
    always_ff @(posedge i_clk) begin
        r_rk[0] <= {r_key_upper, r_key_lower};
        for (int i = 1; i < NStage; i++) begin
            r_rk[i] <= aes128_pkg::next_key(r_rk[i - 1], aes128_pkg::Rcon[i - 1]);
        end
    end

    // stage i advances when it is empty or the one after it advances
    always_comb begin
        w_adv[NStage - 1] = !r_vld[NStage - 1] || i_ready;
        for (int i = NStage - 2; i >= 0; i--) begin
            w_adv[i] = !r_vld[i] || w_adv[i + 1];
        end
    end

    // no new item until the whole key table holds the current key
    assign o_ready = w_adv[0] && (r_kx_cnt == 4'(NStage));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NStage; i++) r_vld[i] <= 1'b0;
        end else begin
            if (w_adv[0]) r_vld[0] <= i_valid && o_ready;
            for (int i = 1; i < NStage; i++) begin
                if (w_adv[i]) r_vld[i] <= r_vld[i - 1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[0]) begin
            r_op[0] <= i_operation;
            r_st[0] <= {i_block_upper, i_block_lower}
                       ^ ((i_operation == aes128_pkg::OpDecrypt) ? r_rk[NStage - 1] : r_rk[0]);
        end
        for (int i = 1; i < NStage; i++) begin
            if (w_adv[i]) begin
                r_op[i] <= r_op[i - 1];
                if (r_op[i - 1] == aes128_pkg::OpDecrypt) begin
                    // inverse: shift, sub, add key, then mix except in the last round
                    if (i == NStage - 1) begin
                        r_st[i] <= aes128_pkg::sub_bytes(
                            aes128_pkg::shift_rows(r_st[i - 1], 1'b1), 1'b1) ^ r_rk[0];
                    end else begin
                        r_st[i] <= aes128_pkg::mix_columns(aes128_pkg::sub_bytes(
                            aes128_pkg::shift_rows(r_st[i - 1], 1'b1), 1'b1)
                            ^ r_rk[NStage - 1 - i], 1'b1);
                    end
                end else begin
                    if (i == NStage - 1) begin
                        r_st[i] <= aes128_pkg::shift_rows(
                            aes128_pkg::sub_bytes(r_st[i - 1], 1'b0), 1'b0) ^ r_rk[i];
                    end else begin
                        r_st[i] <= aes128_pkg::mix_columns(aes128_pkg::shift_rows(
                            aes128_pkg::sub_bytes(r_st[i - 1], 1'b0), 1'b0), 1'b0)
                            ^ r_rk[i];
                    end
                end
            end
        end
    end

    assign o_valid     = r_vld[NStage - 1];
    assign o_out_upper = r_st[NStage - 1][127:64];
    assign o_out_lower = r_st[NStage - 1][63:0];

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_out_upper))
        else $error("stalled output item changed");
    a_ready_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> (r_kx_cnt != 4'(NStage)) || (r_vld[0] && o_valid && !i_ready))
        else $error("input stalled without a full blocked pipe or key refill");
    a_key_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_kx_cnt <= 4'(NStage))
        else $error("key expansion counter overran");

endmodule
`default_nettype wire
